// ===== design/jbce_pkg.sv =====
// types and constants shared by the jtag byte command engine
// no dependencies; used by jbce_phase_gen and jtag_byte_command_engine
package jbce_pkg;

  localparam int unsigned MAX_SHIFT_BYTES = 63;
  localparam int unsigned PHASE_W         = 4;
  localparam int unsigned LAST_PHASE      = 15;

  localparam int unsigned HDR_BIT = 7;
  localparam int unsigned RD_BIT  = 6;

  typedef logic [5:0]         count_t;
  typedef logic [PHASE_W-1:0] phase_t;

  typedef enum logic [2:0] {
    KIND_BITBANG = 3'b001,
    KIND_HEADER  = 3'b010,
    KIND_DATA    = 3'b100
  } kind_t;

  typedef struct packed {
    logic       tck;
    logic       tms;
    logic       tdi;
    logic [2:0] aux;
  } pins_t;

  typedef struct packed {
    pins_t      pins;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic   emit;
    logic   done;
    pins_t  pins_nxt;
    count_t remaining_nxt;
    logic   read_en_nxt;
  } step_t;

endpackage

// ===== design/jbce_phase_gen.sv =====
// per-phase decode of one held command byte: pin result and next engine state
// depends on jbce_pkg
module jbce_phase_gen (
  input  logic [7:0]       cmd_byte,
  input  logic [7:0]       tdo_bits,
  input  jbce_pkg::phase_t phase,
  input  jbce_pkg::pins_t  pins,
  input  jbce_pkg::count_t remaining,
  input  logic             read_en,
  output jbce_pkg::result_t res,
  output jbce_pkg::step_t   step
);

  jbce_pkg::kind_t  kind;
  jbce_pkg::count_t hdr_cnt;
  logic [2:0]       bit_idx;
  logic             final_phase;

  always_comb begin
    if (remaining != '0) begin
      kind = jbce_pkg::KIND_DATA;
    end else if (cmd_byte[jbce_pkg::HDR_BIT]) begin
      kind = jbce_pkg::KIND_HEADER;
    end else begin
      kind = jbce_pkg::KIND_BITBANG;
    end
  end

  // count saturates at the configured maximum
  always_comb begin
    if (cmd_byte[5:0] > jbce_pkg::count_t'(jbce_pkg::MAX_SHIFT_BYTES)) begin
      hdr_cnt = jbce_pkg::count_t'(jbce_pkg::MAX_SHIFT_BYTES);
    end else begin
      hdr_cnt = cmd_byte[5:0];
    end
  end

  assign bit_idx     = phase[3:1];
  assign final_phase = (phase == jbce_pkg::phase_t'(jbce_pkg::LAST_PHASE));

  always_comb begin
    res                = '0;
    res.pins           = pins;
    step.emit          = 1'b0;
    step.done          = 1'b1;
    step.pins_nxt      = pins;
    step.remaining_nxt = remaining;
    step.read_en_nxt   = read_en;
    unique case (kind)
      jbce_pkg::KIND_DATA: begin
        // even phase tck low, odd phase tck high
        res.pins.tck       = phase[0];
        res.pins.tdi       = cmd_byte[bit_idx];
        res.read_valid     = final_phase & read_en;
        res.read_byte      = (final_phase & read_en) ? tdo_bits : 8'h00;
        res.last           = final_phase;
        step.emit          = 1'b1;
        step.done          = final_phase;
        step.pins_nxt.tck  = 1'b1;
        step.pins_nxt.tdi  = cmd_byte[7];
        step.remaining_nxt = remaining - 6'd1;
      end
      jbce_pkg::KIND_HEADER: begin
        step.remaining_nxt = hdr_cnt;
        step.read_en_nxt   = cmd_byte[jbce_pkg::RD_BIT];
      end
      jbce_pkg::KIND_BITBANG: begin
        step.pins_nxt.tck = cmd_byte[0];
        step.pins_nxt.tms = cmd_byte[1];
        step.pins_nxt.tdi = cmd_byte[4];
        step.pins_nxt.aux = {cmd_byte[5], cmd_byte[3], cmd_byte[2]};
        res.pins          = step.pins_nxt;
        res.read_valid    = cmd_byte[jbce_pkg::RD_BIT];
        res.read_byte     = cmd_byte[jbce_pkg::RD_BIT] ? {7'b0, tdo_bits[0]} : 8'h00;
        res.last          = 1'b1;
        step.emit         = 1'b1;
      end
      default: begin
        step.done = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/jtag_byte_command_engine.sv =====
// top level of the jtag byte command engine: input holding register, phase
// counter, pin state and result register; depends on jbce_pkg, jbce_phase_gen
//
// Each host byte is taken into a holding register and turned into pin phases,
// one result transfer per cycle, when not stalled, into a result register. A
// bit-bang byte (bit 7 clear, not inside a shift) gives one result with the
// new pin levels and, when bit 6 is set, TDO bit 0 as the read byte. A header
// byte (bit 7 set) gives no result and loads the shift count (bits 0..5,
// saturated) and the read flag (bit 6). While the count is nonzero every
// byte is shift data: sixteen results, TCK low then high for bits 0 to 7 LSB
// first, the last one carrying the captured TDO byte when the read flag is
// set; the phases of a shift byte are paced by the four-bit phase
// counter. A new byte is taken in the same cycle the previous one finishes.
// While out_stall holds a result in the result register no further phase is
// produced, so a byte that needs a result slot waits and in_stall stays high;
// only a header can still complete. Every result has last set on the final
// phase of its byte.
module jtag_byte_command_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_cmd_byte,
  input  logic [7:0] in_tdo_bits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tck,
  output logic       out_tms,
  output logic       out_tdi,
  output logic [2:0] out_aux_pins,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_last
);

  // holding register for the byte in progress
  logic              hold_v_r;
  logic [7:0]        cmd_r;
  logic [7:0]        tdo_r;
  jbce_pkg::phase_t  phase_r;

  // engine state
  jbce_pkg::pins_t   pins_r;
  jbce_pkg::count_t  remaining_r;
  logic              read_en_r;

  // result register
  logic              out_valid_r;
  jbce_pkg::result_t res_r;

  jbce_pkg::result_t res;
  jbce_pkg::step_t   step;

  logic adv;      // result register can take a new value
  logic fire;     // current phase completes this cycle
  logic consume;  // held byte is finished
  logic take;     // input transfer

  jbce_phase_gen u_phase_gen (
    .cmd_byte  (cmd_r),
    .tdo_bits  (tdo_r),
    .phase     (phase_r),
    .pins      (pins_r),
    .remaining (remaining_r),
    .read_en   (read_en_r),
    .res       (res),
    .step      (step)
  );

  assign adv     = !out_valid_r || !out_stall;
  // a header needs no result slot, every other phase needs one
  assign fire    = hold_v_r && (!step.emit || adv);
  assign consume = fire && step.done;
  assign in_stall = hold_v_r && !consume;
  assign take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (take) begin
      hold_v_r <= 1'b1;
    end else if (consume) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= in_cmd_byte;
      tdo_r <= in_tdo_bits;
    end
  end

  // phase counter steps through the sixteen shift phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (consume) begin
      phase_r <= '0;
    end else if (fire) begin
      phase_r <= phase_r + jbce_pkg::phase_t'(1);
    end
  end

  // state commits once the whole byte is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_r      <= '0;
      remaining_r <= '0;
      read_en_r   <= 1'b0;
    end else if (consume) begin
      pins_r      <= step.pins_nxt;
      remaining_r <= step.remaining_nxt;
      read_en_r   <= step.read_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fire && step.emit) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tck        = res_r.pins.tck;
  assign out_tms        = res_r.pins.tms;
  assign out_tdi        = res_r.pins.tdi;
  assign out_aux_pins   = res_r.pins.aux;
  assign out_read_valid = res_r.read_valid;
  assign out_read_byte  = res_r.read_byte;
  assign out_last       = res_r.last;

endmodule
